### rtl/pei_pkg.sv
`timescale 1ns / 1ps

package pei_pkg;

   localparam int FIELD_W = 32;
   localparam int MASS_W  = 25;
   localparam int DT_W    = 16;
   localparam int DT_FRAC = 16;
   localparam int SPLIT_W = 24;
   localparam int MAG_W   = 48;
   localparam int PROD_W  = 49;
   localparam int RES_W   = 50;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_INV_MASS = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_LOCKED   = CSR_IDX_W'(1);

   typedef enum logic [1:0] {
      OP_FORCE = 2'd0,
      OP_SIM   = 2'd1,
      OP_SETP  = 2'd2,
      OP_SETV  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      PH_NONE,
      PH_LO,
      PH_HI,
      PH_FIN
   } phase_type;

   typedef enum logic [1:0] {
      OPND_FORCE,
      OPND_RES,
      OPND_VEL
   } opnd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_M1_LO,
      ST_M1_HI,
      ST_M1_FIN,
      ST_M2_LO,
      ST_M2_HI,
      ST_M2_FIN,
      ST_VEL,
      ST_M3_LO,
      ST_M3_HI,
      ST_M3_FIN,
      ST_POS,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic      cap;
      opnd_type  opnd;
      logic      b_mass;
      phase_type phase;
      logic      force_add;
      logic      force_clr;
      logic      pos_load;
      logic      vel_load;
      logic      vel_acc;
      logic      pos_acc;
   } ctrl_type;

endpackage

### rtl/pei_mul.sv
`timescale 1ns / 1ps

module pei_mul #(
   parameter int WORD_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                          clock,
   input  pei_pkg::phase_type            phase,
   input  logic                          frac_sh,
   input  logic signed [WORD_WIDTH-1:0]  opnd,
   input  logic [pei_pkg::MASS_W-1:0]    mult,
   output logic signed [WORD_WIDTH-1:0]  result
);
   import pei_pkg::*;

   localparam logic [RES_W-1:0] LIM = RES_W'(1) << (WORD_WIDTH - 1);
   localparam logic [4:0] UP_F = 5'(SPLIT_W - FRAC_BITS);
   localparam logic [4:0] UP_D = 5'(SPLIT_W - DT_FRAC);
   localparam logic [4:0] SH_F = 5'(FRAC_BITS);
   localparam logic [4:0] SH_D = 5'(DT_FRAC);

   logic signed [MAG_W:0]     opnd_ext;
   logic [MAG_W:0]            mag_full;
   logic [MAG_W-1:0]          mag;
   logic [PROD_W-1:0]         p_lo;
   logic [4:0]                up;
   logic [4:0]                sh;
   logic [RES_W-1:0]          thr;
   logic [RES_W-1:0]          phi_x;
   logic [RES_W-1:0]          sum;
   logic [RES_W-1:0]          r;
   logic [RES_W-1:0]          rp;
   logic signed [WORD_WIDTH-1:0] res_fin;

   logic                      neg_ff;
   logic [SPLIT_W-1:0]        mhi_ff;
   logic [PROD_W-1:0]         plo_ff;
   logic [PROD_W-1:0]         phi_ff;
   logic signed [WORD_WIDTH-1:0] result_ff;

   // magnitude and low partial product
   always_comb begin
      opnd_ext = {{(MAG_W + 1 - WORD_WIDTH){opnd[WORD_WIDTH-1]}}, opnd};
      mag_full = opnd_ext[MAG_W] ? ((MAG_W+1)'(0) - opnd_ext) : opnd_ext;
      mag      = mag_full[MAG_W-1:0];
      p_lo     = PROD_W'(mag[SPLIT_W-1:0]) * PROD_W'(mult);
   end

   // shift, sign and saturation
   always_comb begin
      up    = frac_sh ? UP_F : UP_D;
      sh    = frac_sh ? SH_F : SH_D;
      thr   = LIM >> up;
      phi_x = RES_W'(phi_ff);
      sum   = (phi_x << up) + (RES_W'(plo_ff) >> sh);
      if (phi_x > thr) begin
         r = LIM;
      end else if (sum > LIM) begin
         r = LIM;
      end else begin
         r = sum;
      end
      rp = (r > LIM - RES_W'(1)) ? (LIM - RES_W'(1)) : r;
      res_fin = neg_ff ? WORD_WIDTH'(RES_W'(0) - r) : WORD_WIDTH'(rp);
   end

   always_ff @(posedge clock) begin
      case (phase)
         PH_LO: begin
            neg_ff <= opnd[WORD_WIDTH-1];
            mhi_ff <= mag[MAG_W-1:SPLIT_W];
            plo_ff <= p_lo;
         end
         PH_HI: begin
            phi_ff <= PROD_W'(mhi_ff) * PROD_W'(mult);
         end
         PH_FIN: begin
            result_ff <= res_fin;
         end
         default: begin
         end
      endcase
   end

   assign result = result_ff;

endmodule

### rtl/pei_lane.sv
`timescale 1ns / 1ps

module pei_lane #(
   parameter int WORD_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  pei_pkg::ctrl_type                   ctrl,
   input  logic signed [pei_pkg::FIELD_W-1:0]  vec,
   input  logic [pei_pkg::DT_W-1:0]            time_step,
   input  logic [pei_pkg::MASS_W-1:0]          inv_mass,
   output logic signed [pei_pkg::FIELD_W-1:0]  pos_out,
   output logic signed [pei_pkg::FIELD_W-1:0]  vel_out
);
   import pei_pkg::*;

   localparam int EXT_W = (WORD_WIDTH > FIELD_W) ? WORD_WIDTH : FIELD_W;
   localparam logic signed [EXT_W:0] MAXV =
      {{(EXT_W - WORD_WIDTH + 2){1'b0}}, {(WORD_WIDTH - 1){1'b1}}};
   localparam logic signed [EXT_W:0] MINV =
      {{(EXT_W - WORD_WIDTH + 2){1'b1}}, {(WORD_WIDTH - 1){1'b0}}};
   localparam logic signed [WORD_WIDTH-1:0] WMAX = {1'b0, {(WORD_WIDTH - 1){1'b1}}};
   localparam logic signed [WORD_WIDTH-1:0] WMIN = {1'b1, {(WORD_WIDTH - 1){1'b0}}};

   logic signed [WORD_WIDTH-1:0] pos_ff;
   logic signed [WORD_WIDTH-1:0] pos_in;
   logic signed [WORD_WIDTH-1:0] vel_ff;
   logic signed [WORD_WIDTH-1:0] vel_in;
   logic signed [WORD_WIDTH-1:0] force_ff;
   logic signed [WORD_WIDTH-1:0] force_in;
   logic signed [WORD_WIDTH-1:0] vec_ff;

   logic signed [EXT_W:0]        vec_ext;
   logic signed [EXT_W:0]        vec_clip;
   logic signed [WORD_WIDTH-1:0] mul_opnd;
   logic [MASS_W-1:0]            mul_b;
   logic signed [WORD_WIDTH-1:0] mul_res;
   logic signed [WORD_WIDTH-1:0] add_a;
   logic signed [WORD_WIDTH-1:0] add_b;
   logic signed [WORD_WIDTH:0]   add_sum;
   logic signed [WORD_WIDTH-1:0] add_sat;
   logic signed [EXT_W:0]        pos_ext;
   logic signed [EXT_W:0]        vel_ext;

   // input field to word range
   always_comb begin
      vec_ext = {{(EXT_W - FIELD_W + 1){vec[FIELD_W-1]}}, vec};
      if (vec_ext > MAXV) begin
         vec_clip = MAXV;
      end else if (vec_ext < MINV) begin
         vec_clip = MINV;
      end else begin
         vec_clip = vec_ext;
      end
   end

   always_comb begin
      case (ctrl.opnd)
         OPND_RES: mul_opnd = mul_res;
         OPND_VEL: mul_opnd = vel_ff;
         default:  mul_opnd = force_ff;
      endcase
      mul_b = ctrl.b_mass ? inv_mass : MASS_W'(time_step);
   end

   pei_mul #(
      .WORD_WIDTH(WORD_WIDTH),
      .FRAC_BITS (FRAC_BITS)
   ) u_mul (
      .clock  (clock),
      .phase  (ctrl.phase),
      .frac_sh(ctrl.b_mass),
      .opnd   (mul_opnd),
      .mult   (mul_b),
      .result (mul_res)
   );

   // shared saturating adder
   always_comb begin
      if (ctrl.force_add) begin
         add_a = force_ff;
         add_b = vec_ff;
      end else if (ctrl.vel_acc) begin
         add_a = vel_ff;
         add_b = mul_res;
      end else begin
         add_a = pos_ff;
         add_b = mul_res;
      end
      add_sum = {add_a[WORD_WIDTH-1], add_a} + {add_b[WORD_WIDTH-1], add_b};
      if (add_sum[WORD_WIDTH] != add_sum[WORD_WIDTH-1]) begin
         add_sat = add_sum[WORD_WIDTH] ? WMIN : WMAX;
      end else begin
         add_sat = add_sum[WORD_WIDTH-1:0];
      end
   end

   always_comb begin
      pos_in   = pos_ff;
      vel_in   = vel_ff;
      force_in = force_ff;
      if (ctrl.pos_load) begin
         pos_in = vec_ff;
      end
      if (ctrl.pos_acc) begin
         pos_in = add_sat;
      end
      if (ctrl.vel_load) begin
         vel_in = vec_ff;
      end
      if (ctrl.vel_acc) begin
         vel_in = add_sat;
      end
      if (ctrl.force_add) begin
         force_in = add_sat;
      end
      if (ctrl.force_clr) begin
         force_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         vel_ff   <= '0;
         force_ff <= '0;
      end else begin
         pos_ff   <= pos_in;
         vel_ff   <= vel_in;
         force_ff <= force_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.cap) begin
         vec_ff <= vec_clip[WORD_WIDTH-1:0];
      end
   end

   always_comb begin
      pos_ext = {{(EXT_W - WORD_WIDTH + 1){pos_ff[WORD_WIDTH-1]}}, pos_ff};
      vel_ext = {{(EXT_W - WORD_WIDTH + 1){vel_ff[WORD_WIDTH-1]}}, vel_ff};
   end

   assign pos_out = pos_ext[FIELD_W-1:0];
   assign vel_out = vel_ext[FIELD_W-1:0];

endmodule

### rtl/particle_euler_integrator.sv
`timescale 1ns / 1ps

// Point-mass integrator in signed fixed point, one lane per axis. An item is taken
// when start is high and busy is low; its result (position and velocity after the
// item) appears on the rsp_ ports for one cycle with rsp_valid high, and the receiver
// cannot stall it. Add-force, set-position, set-velocity and locked simulate items
// occupy the block through an execute and a done state; an unlocked simulate item
// is carried by each lane's three-phase multiplier, used three times in sequence
// (F*inverse_mass, a*dt, v*dt) with a saturating add after the second and third.
// The result strobe comes in the first cycle that busy is low again. Configuration
// writes are always ready and must be made while the block is idle.

module particle_euler_integrator #(
   parameter int WORD_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [1:0]                           req_op,
   input  logic signed [pei_pkg::FIELD_W-1:0]   req_vec_x,
   input  logic signed [pei_pkg::FIELD_W-1:0]   req_vec_y,
   input  logic signed [pei_pkg::FIELD_W-1:0]   req_vec_z,
   input  logic [pei_pkg::DT_W-1:0]             req_time_step,
   output logic                                 rsp_valid,
   output logic signed [pei_pkg::FIELD_W-1:0]   rsp_pos_x,
   output logic signed [pei_pkg::FIELD_W-1:0]   rsp_pos_y,
   output logic signed [pei_pkg::FIELD_W-1:0]   rsp_pos_z,
   output logic signed [pei_pkg::FIELD_W-1:0]   rsp_vel_x,
   output logic signed [pei_pkg::FIELD_W-1:0]   rsp_vel_y,
   output logic signed [pei_pkg::FIELD_W-1:0]   rsp_vel_z,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [pei_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [pei_pkg::CSR_DATA_W-1:0]       csr_data
);
   import pei_pkg::*;

   state_type           state_ff;
   state_type           state_in;
   op_type              op_ff;
   logic [DT_W-1:0]     dt_ff;
   logic [MASS_W-1:0]   inv_mass_ff;
   logic                locked_ff;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                accept;
   ctrl_type            ctrl;

   logic signed [FIELD_W-1:0] vec_lane [3];
   logic signed [FIELD_W-1:0] pos_lane [3];
   logic signed [FIELD_W-1:0] vel_lane [3];
   logic signed [FIELD_W-1:0] pos_rsp_ff [3];
   logic signed [FIELD_W-1:0] vel_rsp_ff [3];

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         inv_mass_ff <= MASS_W'(65536);
         locked_ff   <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_INV_MASS: inv_mass_ff <= csr_data[MASS_W-1:0];
            CSR_LOCKED:   locked_ff   <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff <= op_type'(req_op);
         dt_ff <= req_time_step;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (op_type'(req_op) == OP_SIM && !locked_ff) begin
                  state_in = ST_M1_LO;
               end else begin
                  state_in = ST_EXEC;
               end
            end
         end
         ST_EXEC:   state_in = ST_DONE;
         ST_M1_LO:  state_in = ST_M1_HI;
         ST_M1_HI:  state_in = ST_M1_FIN;
         ST_M1_FIN: state_in = ST_M2_LO;
         ST_M2_LO:  state_in = ST_M2_HI;
         ST_M2_HI:  state_in = ST_M2_FIN;
         ST_M2_FIN: state_in = ST_VEL;
         ST_VEL:    state_in = ST_M3_LO;
         ST_M3_LO:  state_in = ST_M3_HI;
         ST_M3_HI:  state_in = ST_M3_FIN;
         ST_M3_FIN: state_in = ST_POS;
         ST_POS:    state_in = ST_DONE;
         ST_DONE:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // lane control
   always_comb begin
      ctrl           = '0;
      ctrl.opnd      = OPND_FORCE;
      ctrl.phase     = PH_NONE;
      ctrl.cap       = accept;
      rsp_valid_in   = 1'b0;
      unique case (state_ff)
         ST_EXEC: begin
            unique case (op_ff)
               OP_FORCE: ctrl.force_add = !locked_ff;
               OP_SETP:  ctrl.pos_load  = 1'b1;
               OP_SETV:  ctrl.vel_load  = 1'b1;
               default: begin
               end
            endcase
         end
         ST_M1_LO: begin
            ctrl.b_mass = 1'b1;
            ctrl.phase  = PH_LO;
         end
         ST_M1_HI: begin
            ctrl.b_mass = 1'b1;
            ctrl.phase  = PH_HI;
         end
         ST_M1_FIN: begin
            ctrl.b_mass = 1'b1;
            ctrl.phase  = PH_FIN;
         end
         ST_M2_LO: begin
            ctrl.opnd  = OPND_RES;
            ctrl.phase = PH_LO;
         end
         ST_M2_HI: begin
            ctrl.opnd  = OPND_RES;
            ctrl.phase = PH_HI;
         end
         ST_M2_FIN: begin
            ctrl.opnd  = OPND_RES;
            ctrl.phase = PH_FIN;
         end
         ST_VEL: begin
            ctrl.vel_acc = 1'b1;
         end
         ST_M3_LO: begin
            ctrl.opnd  = OPND_VEL;
            ctrl.phase = PH_LO;
         end
         ST_M3_HI: begin
            ctrl.opnd  = OPND_VEL;
            ctrl.phase = PH_HI;
         end
         ST_M3_FIN: begin
            ctrl.opnd  = OPND_VEL;
            ctrl.phase = PH_FIN;
         end
         ST_POS: begin
            ctrl.pos_acc   = 1'b1;
            ctrl.force_clr = 1'b1;
         end
         ST_DONE: begin
            rsp_valid_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign vec_lane[0] = req_vec_x;
   assign vec_lane[1] = req_vec_y;
   assign vec_lane[2] = req_vec_z;

   for (genvar g = 0; g < 3; g++) begin : g_lane
      pei_lane #(
         .WORD_WIDTH(WORD_WIDTH),
         .FRAC_BITS (FRAC_BITS)
      ) u_lane (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .vec      (vec_lane[g]),
         .time_step(dt_ff),
         .inv_mass (inv_mass_ff),
         .pos_out  (pos_lane[g]),
         .vel_out  (vel_lane[g])
      );

      // merge of lane state into the result register
      always_ff @(posedge clock) begin
         if (rsp_valid_in) begin
            pos_rsp_ff[g] <= pos_lane[g];
            vel_rsp_ff[g] <= vel_lane[g];
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pos_x = pos_rsp_ff[0];
   assign rsp_pos_y = pos_rsp_ff[1];
   assign rsp_pos_z = pos_rsp_ff[2];
   assign rsp_vel_x = vel_rsp_ff[0];
   assign rsp_vel_y = vel_rsp_ff[1];
   assign rsp_vel_z = vel_rsp_ff[2];

endmodule

### bench/pei_checker.sv
`timescale 1ns / 1ps

module pei_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic                                 busy,
   input  logic [1:0]                           req_op,
   input  logic signed [pei_pkg::FIELD_W-1:0]   req_vec_x,
   input  logic signed [pei_pkg::FIELD_W-1:0]   req_vec_y,
   input  logic signed [pei_pkg::FIELD_W-1:0]   req_vec_z,
   input  logic [pei_pkg::DT_W-1:0]             req_time_step,
   input  logic                                 rsp_valid,
   input  logic signed [pei_pkg::FIELD_W-1:0]   rsp_pos_x,
   input  logic signed [pei_pkg::FIELD_W-1:0]   rsp_pos_y,
   input  logic signed [pei_pkg::FIELD_W-1:0]   rsp_pos_z,
   input  logic signed [pei_pkg::FIELD_W-1:0]   rsp_vel_x,
   input  logic signed [pei_pkg::FIELD_W-1:0]   rsp_vel_y,
   input  logic signed [pei_pkg::FIELD_W-1:0]   rsp_vel_z,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [pei_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [pei_pkg::CSR_DATA_W-1:0]       csr_data,
   output int                                   outstanding,
   output int                                   mismatches
);
   import pei_pkg::*;

   typedef struct packed {
      logic [2:0][FIELD_W-1:0] pos;
      logic [2:0][FIELD_W-1:0] vel;
   } kinematics_type;

   localparam int     FRAC_BITS = 16;
   localparam longint WORD_MAX  = 64'sd2147483647;
   localparam longint WORD_MIN  = -64'sd2147483648;

   logic signed [FIELD_W-1:0] position [3];
   logic signed [FIELD_W-1:0] velocity [3];
   logic signed [FIELD_W-1:0] force_sum [3];
   logic [MASS_W-1:0]         inv_mass;
   logic                      frozen;
   kinematics_type            expected_states [$];
   kinematics_type            observed;
   int                        fault_count;
   string                     axis_name [3] = '{"x", "y", "z"};

   assign observed = {rsp_pos_z, rsp_pos_y, rsp_pos_x, rsp_vel_z, rsp_vel_y, rsp_vel_x};

   function automatic logic signed [FIELD_W-1:0] clamp_word(longint v);
      if (v > WORD_MAX) return WORD_MAX[FIELD_W-1:0];
      if (v < WORD_MIN) return WORD_MIN[FIELD_W-1:0];
      return v[FIELD_W-1:0];
   endfunction

   // sign kept, magnitude truncated toward zero, saturated to the word
   function automatic longint scaled_product(longint a, longint unsigned b, int sh);
      longint unsigned mag;
      longint unsigned prod;
      longint unsigned lim;
      lim = 64'd1 << (FIELD_W - 1);
      mag = (a < 0) ? -a : a;
      prod = (mag * b) >> sh;
      if (prod > lim) prod = lim;
      if (a < 0) return -longint'(prod);
      if (prod > lim - 1) prod = lim - 1;
      return longint'(prod);
   endfunction

   task automatic flag_error(string msg);
      $display("%0t: %s", $time, msg);
      fault_count++;
   endtask

   task automatic integrate_item(op_type op, logic signed [FIELD_W-1:0] vx,
                                 logic signed [FIELD_W-1:0] vy,
                                 logic signed [FIELD_W-1:0] vz, logic [DT_W-1:0] dt);
      logic signed [FIELD_W-1:0] vec [3];
      longint accel;
      vec[0] = vx;
      vec[1] = vy;
      vec[2] = vz;
      for (int i = 0; i < 3; i++) begin
         case (op)
            OP_FORCE: begin
               if (!frozen) force_sum[i] = clamp_word(longint'(force_sum[i]) + longint'(vec[i]));
            end
            OP_SIM: begin
               if (!frozen) begin
                  accel = scaled_product(force_sum[i], inv_mass, FRAC_BITS);
                  velocity[i] = clamp_word(longint'(velocity[i])
                                           + scaled_product(accel, dt, DT_FRAC));
                  position[i] = clamp_word(longint'(position[i])
                                           + scaled_product(velocity[i], dt, DT_FRAC));
                  force_sum[i] = '0;
               end
            end
            OP_SETP: position[i] = vec[i];
            OP_SETV: velocity[i] = vec[i];
         endcase
      end
   endtask

   always @(posedge clock) begin
      kinematics_type want;
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            position[i] = '0;
            velocity[i] = '0;
            force_sum[i] = '0;
         end
         inv_mass = MASS_W'(65536);
         frozen = 1'b0;
         expected_states.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_states.size() == 0) begin
               flag_error("result with no item pending");
            end else begin
               want = expected_states.pop_front();
               for (int i = 0; i < 3; i++) begin
                  if (observed.pos[i] !== want.pos[i])
                     flag_error($sformatf("pos_%s got %h expected %h", axis_name[i],
                                          observed.pos[i], want.pos[i]));
                  if (observed.vel[i] !== want.vel[i])
                     flag_error($sformatf("vel_%s got %h expected %h", axis_name[i],
                                          observed.vel[i], want.vel[i]));
               end
            end
         end
         if (start && !busy) begin
            integrate_item(op_type'(req_op), req_vec_x, req_vec_y, req_vec_z, req_time_step);
            for (int i = 0; i < 3; i++) begin
               want.pos[i] = position[i];
               want.vel[i] = velocity[i];
            end
            expected_states.push_back(want);
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_INV_MASS: inv_mass = csr_data[MASS_W-1:0];
               CSR_LOCKED:   frozen = csr_data[0];
               default: ;
            endcase
         end
      end
      outstanding <= expected_states.size();
      mismatches <= fault_count;
   end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import pei_pkg::*;

   localparam int LIMIT_CYCLES = 400000;

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        start;
   logic                        busy;
   logic [1:0]                  req_op;
   logic signed [FIELD_W-1:0]   req_vec_x;
   logic signed [FIELD_W-1:0]   req_vec_y;
   logic signed [FIELD_W-1:0]   req_vec_z;
   logic [DT_W-1:0]             req_time_step;
   logic                        rsp_valid;
   logic signed [FIELD_W-1:0]   rsp_pos_x;
   logic signed [FIELD_W-1:0]   rsp_pos_y;
   logic signed [FIELD_W-1:0]   rsp_pos_z;
   logic signed [FIELD_W-1:0]   rsp_vel_x;
   logic signed [FIELD_W-1:0]   rsp_vel_y;
   logic signed [FIELD_W-1:0]   rsp_vel_z;
   logic                        csr_valid;
   logic                        csr_ready;
   logic [CSR_IDX_W-1:0]        csr_index;
   logic [CSR_DATA_W-1:0]       csr_data;
   int                          outstanding;
   int                          mismatches;
   int                          cycle_count = 0;

   always #6 clock = ~clock;

   particle_euler_integrator u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(req_op), .req_vec_x(req_vec_x), .req_vec_y(req_vec_y),
      .req_vec_z(req_vec_z), .req_time_step(req_time_step),
      .rsp_valid(rsp_valid), .rsp_pos_x(rsp_pos_x), .rsp_pos_y(rsp_pos_y),
      .rsp_pos_z(rsp_pos_z), .rsp_vel_x(rsp_vel_x), .rsp_vel_y(rsp_vel_y),
      .rsp_vel_z(rsp_vel_z), .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   pei_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(req_op), .req_vec_x(req_vec_x), .req_vec_y(req_vec_y),
      .req_vec_z(req_vec_z), .req_time_step(req_time_step),
      .rsp_valid(rsp_valid), .rsp_pos_x(rsp_pos_x), .rsp_pos_y(rsp_pos_y),
      .rsp_pos_z(rsp_pos_z), .rsp_vel_x(rsp_vel_x), .rsp_vel_y(rsp_vel_y),
      .rsp_vel_z(rsp_vel_z), .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .outstanding(outstanding), .mismatches(mismatches)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("particle_euler_integrator: mismatch");
         $finish;
      end
   end

   task automatic send_item(op_type op, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            logic [DT_W-1:0] dt);
      req_op <= op;
      req_vec_x <= x;
      req_vec_y <= y;
      req_vec_z <= z;
      req_time_step <= dt;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // both registers back to back, valid held high across the pair
   task automatic program_particle(logic [CSR_DATA_W-1:0] mass, logic hold);
      csr_valid <= 1'b1;
      csr_index <= CSR_INV_MASS;
      csr_data <= mass;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_index <= CSR_LOCKED;
      csr_data <= {{(CSR_DATA_W-1){1'b0}}, hold};
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic op_type pick_op();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 40) return OP_FORCE;
      if (sel < 75) return OP_SIM;
      if (sel < 87) return OP_SETP;
      return OP_SETV;
   endfunction

   function automatic logic [31:0] pick_component();
      int sel;
      logic [31:0] mag;
      sel = $urandom_range(0, 99);
      if (sel < 60) begin
         mag = $urandom_range(0, 32'h0040_0000);
         return $urandom_range(0, 1) ? -mag : mag;
      end
      if (sel < 85) return $urandom();
      case ($urandom_range(0, 3))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'hFFFF_FFFF;
         default: return 32'h0000_0000;
      endcase
   endfunction

   function automatic logic [DT_W-1:0] pick_step();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 10) return '0;
      if (sel < 20) return '1;
      return DT_W'($urandom_range(0, 16'hFFFF));
   endfunction

   initial begin
      logic [CSR_DATA_W-1:0] mass;
      logic                  hold;
      int                    pct;
      reset <= 1'b1;
      start <= 1'b0;
      req_op <= OP_FORCE;
      req_vec_x <= '0;
      req_vec_y <= '0;
      req_vec_z <= '0;
      req_time_step <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_INV_MASS;
      csr_data <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // extremes, saturation and zero steps at the reset setting
      send_item(OP_SETP, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 16'h0000);
      send_item(OP_SETV, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
      send_item(OP_FORCE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 16'h1234);
      send_item(OP_FORCE, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_0000, 16'h0000);
      send_item(OP_SIM, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'hFFFF);
      send_item(OP_SIM, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0000);
      send_item(OP_SETP, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'h0000);
      send_item(OP_SETV, 32'h0001_8000, 32'hFFFE_8000, 32'h0000_0001, 16'h0000);
      send_item(OP_FORCE, 32'h0003_0000, 32'hFFFD_0000, 32'h0000_0001, 16'h0000);
      send_item(OP_SIM, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'h8000);
      send_item(OP_SIM, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'h0001);
      send_item(OP_FORCE, 32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678, 16'hAAAA);
      send_item(OP_SIM, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'h5555);
      send_item(OP_FORCE, 32'h0002_0000, 32'hFFFE_0000, 32'h0000_4000, 16'h0000);
      settle();

      // locked: force and step leave state alone, loads still apply
      program_particle(32'h01FF_FFFF, 1'b1);
      send_item(OP_FORCE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 16'h0000);
      send_item(OP_SIM, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'hFFFF);
      send_item(OP_SETP, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003, 16'h0000);
      send_item(OP_SETV, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFD, 16'h0000);
      settle();
      program_particle(32'h01FF_FFFF, 1'b0);
      send_item(OP_SIM, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'hFFFF);
      send_item(OP_FORCE, 32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF, 16'h0000);
      send_item(OP_SIM, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'hFFFF);
      settle();
      program_particle(32'h0000_0000, 1'b0);
      send_item(OP_FORCE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0100_0000, 16'h0000);
      send_item(OP_SIM, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'hFFFF);

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin mass = 32'h0001_0000; hold = 1'b0; pct = 0; end
            1: begin mass = 32'h01FF_FFFF; hold = 1'b0; pct = 57; end
            2: begin mass = 32'h0000_0000; hold = 1'b0; pct = 19; end
            3: begin mass = $urandom_range(0, 32'h01FF_FFFF); hold = 1'b1; pct = 57; end
            4: begin mass = 32'h0100_0000; hold = 1'b0; pct = 0; end
            default: begin mass = $urandom_range(0, 32'h0002_0000); hold = 1'b0; pct = 19; end
         endcase
         settle();
         program_particle(mass, hold);
         for (int n = 0; n < 140; n++) begin
            send_item(pick_op(), pick_component(), pick_component(), pick_component(),
                      pick_step());
            if (n == 70) begin
               settle();
            end else if ($urandom_range(0, 99) < pct) begin
               start <= 1'b0;
               repeat ($urandom_range(1, 16)) @(posedge clock);
            end
         end
      end

      settle();
      repeat (16) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("particle_euler_integrator: match");
      end else begin
         $display("particle_euler_integrator: mismatch");
      end
      $finish;
   end

endmodule

### particle_euler_integrator.f
rtl/pei_pkg.sv
rtl/pei_mul.sv
rtl/pei_lane.sv
rtl/particle_euler_integrator.sv
bench/pei_checker.sv
bench/tb_top.sv
